### rtl/core/sorted_priority_queue_assert.svh
// Assertion macros used by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int PRIO_W   = 16;
  localparam int FIELD_DW = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // mode field codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage

### rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::spq_op_t                 op,
  input  logic [DATA_WIDTH-1:0]            new_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] new_prio,
  // neighbor toward the head
  input  logic                             left_stay,
  input  logic                             left_valid,
  input  logic [DATA_WIDTH-1:0]            left_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
  // neighbor toward the tail
  input  logic                             right_valid,
  input  logic [DATA_WIDTH-1:0]            right_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                             stay,
  output logic                             valid,
  output logic [DATA_WIDTH-1:0]            data,
  output logic signed [spq_pkg::PRIO_W-1:0] prio
);

  // entry stays put on insert when it sorts at or before the new one
  assign stay = valid && (prio <= new_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ins) begin
      if (!stay) begin
        valid <= left_stay ? 1'b1 : left_valid;
      end
    end else if (op.rem) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (!stay) begin
        if (left_stay) begin
          data <= new_data;
          prio <= new_prio;
        end else begin
          data <= left_data;
          prio <= left_prio;
        end
      end
    end else if (op.rem) begin
      data <= right_data;
      prio <= right_prio;
    end
  end

endmodule

### rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted in a row of cells; smallest priority at the head.
// ----------------------------------------------------------------------------
//  channel  dir  word fields (lsb first)
//  s_axis   in   tdata: new_data[31:0] new_priority[47:32]; tuser: mode
//  m_axis   out  tdata: head_data[31:0] head_priority[47:32] head_valid[48]
//                       entry_count[53:49] status[55:54]
//
//  One word per cycle unless m_axis stalls; all cells compare and shift at once.
//  Result of a word is shown the cycle after it is taken, from cell 0.
//  s_axis_tready is high out of reset while the result slot is empty or
//  being drained.
//  Reset clears only the valid bits of the cells, not their contents.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // new_data, new_priority
  input  logic [0:0]                         s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // head_data, head_priority, head_valid, entry_count, status
  output logic [spq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = spq_pkg::PRIO_W;

  logic                         accept;
  logic                         mode;
  logic                         full;
  logic                         empty;
  logic [DATA_WIDTH-1:0]        in_data;
  logic signed [PW-1:0]         in_prio;
  spq_pkg::spq_op_t             op;
  logic [CW-1:0]                count;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::STATUS_W-1:0] status_next;

  logic                         cell_stay  [DEPTH];
  logic                         cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0]        cell_data  [DEPTH];
  logic signed [PW-1:0]         cell_prio  [DEPTH];

  logic [spq_pkg::FIELD_DW-1:0] head_data;
  logic [PW-1:0]                head_prio;

  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = s_axis_tuser[0];
  assign in_data       = DATA_WIDTH'(s_axis_tdata[spq_pkg::FIELD_DW-1:0]);
  assign in_prio       = s_axis_tdata[spq_pkg::FIELD_DW +: PW];

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign op.ins = accept && (mode == spq_pkg::MODE_INSERT) && !full;
  assign op.rem = accept && (mode == spq_pkg::MODE_REMOVE) && !empty;

  always_comb begin
    status_next = spq_pkg::STAT_OK;
    if (mode == spq_pkg::MODE_INSERT && full) begin
      status_next = spq_pkg::STAT_FULL;
    end else if (mode == spq_pkg::MODE_REMOVE && empty) begin
      status_next = spq_pkg::STAT_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_stay;
    logic                  l_valid;
    logic [DATA_WIDTH-1:0] l_data;
    logic signed [PW-1:0]  l_prio;
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic signed [PW-1:0]  r_prio;

    if (i == 0) begin : g_head
      // nothing ahead of the head: new entry lands here unless it stays
      assign l_stay  = 1'b1;
      assign l_valid = 1'b0;
      assign l_data  = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_stay  = cell_stay[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_data  = cell_data[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_data  = cell_data[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_data    (in_data),
      .new_prio    (in_prio),
      .left_stay   (l_stay),
      .left_valid  (l_valid),
      .left_data   (l_data),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_data  (r_data),
      .right_prio  (r_prio),
      .stay        (cell_stay[i]),
      .valid       (cell_valid[i]),
      .data        (cell_data[i]),
      .prio        (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (op.ins) begin
        count <= count + 1'b1;
      end else if (op.rem) begin
        count <= count - 1'b1;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // cells only move on accept, which needs the result slot free, so the
  // head read live here is the head left by the word being reported
  assign head_data = cell_valid[0] ? spq_pkg::FIELD_DW'(cell_data[0]) : '0;
  assign head_prio = cell_valid[0] ? cell_prio[0] : '0;

  assign m_axis_tdata = {status, spq_pkg::COUNT_W'(count), cell_valid[0],
                         head_prio, head_data};

  `SPQ_ASSERT_NOW(a_head_vs_count, 1'b1, cell_valid[0] == (count != '0), "head valid disagrees with count")
  `SPQ_ASSERT_NOW(a_head_sorted, cell_valid[0] && cell_valid[1], cell_prio[0] <= cell_prio[1], "head not smallest")
  `SPQ_ASSERT_NEXT(a_ins_count, op.ins, count == $past(count) + 1'b1, "insert did not grow count")
  `SPQ_ASSERT_NEXT(a_full_flag, accept && (mode == spq_pkg::MODE_INSERT) && full, status == spq_pkg::STAT_FULL && full, "insert on full not flagged")

endmodule

### sim/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A directed table covers
// the empty, full and tie cases and the priority extremes. Random command
// streams then sweep the fill level between empty and full. Every result
// word is checked field by field against the software copy or a given report.
// Sender and receiver stall at random, and the receiver holds off once for
// a long stretch so that the queue backs up and stops taking words.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

  localparam int QDEPTH      = spq_pkg::DEPTH_DEFAULT;
  localparam int RAND_WORDS  = 1900;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 16;

  // same bit layout as m_axis_tdata, lsb field last
  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0]     status;
    logic [spq_pkg::COUNT_W-1:0]      count;
    logic                             valid;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::FIELD_DW-1:0]     data;
  } head_report_t;

  typedef struct packed {
    logic                         mode;
    logic [spq_pkg::FIELD_DW-1:0] data;
    logic [spq_pkg::PRIO_W-1:0]   prio;
    logic                         typed;
    head_report_t                 want;
  } dir_row_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // new_data, new_priority
  logic [0:0]                      s_axis_tuser;   // mode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // head_data, head_priority, head_valid, entry_count, status
  logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  sorted_priority_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // software copy of the queue
  logic [spq_pkg::FIELD_DW-1:0]      model_payload [QDEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] model_prio [QDEPTH];
  int                                model_count;

  head_report_t expected_heads[$];
  dir_row_t     directed_rows[$];

  int error_count;
  int checked_count;
  int insert_count;
  int remove_count;
  int full_drops;
  int empty_removes;
  int peak_fill;

  int   src_idle_pct;
  int   snk_idle_pct;
  logic hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic head_report_t mk_report(input logic [spq_pkg::STATUS_W-1:0] st,
                                             input logic [spq_pkg::COUNT_W-1:0] cnt,
                                             input logic v,
                                             input logic [spq_pkg::PRIO_W-1:0] p,
                                             input logic [spq_pkg::FIELD_DW-1:0] d);
    head_report_t r;
    r.status = st;
    r.count  = cnt;
    r.valid  = v;
    r.prio   = p;
    r.data   = d;
    return r;
  endfunction

  // Sorted insert (after all entries of lower or equal priority) or head pop.
  task automatic advance_queue_model(input logic m,
                                     input logic [spq_pkg::FIELD_DW-1:0] d,
                                     input logic [spq_pkg::PRIO_W-1:0] p_raw,
                                     output head_report_t r);
    logic signed [spq_pkg::PRIO_W-1:0] p;
    logic [spq_pkg::STATUS_W-1:0]      st;
    int                                pos;
    int                                i;
    p  = p_raw;
    st = spq_pkg::STAT_OK;
    if (m == spq_pkg::MODE_INSERT) begin
      insert_count++;
      if (model_count >= QDEPTH) begin
        st = spq_pkg::STAT_FULL;
        full_drops++;
      end else begin
        pos = 0;
        while (pos < model_count && model_prio[pos] <= p) pos++;
        for (i = model_count; i > pos; i--) begin
          model_payload[i] = model_payload[i-1];
          model_prio[i]    = model_prio[i-1];
        end
        model_payload[pos] = d;
        model_prio[pos]    = p;
        model_count++;
        if (model_count > peak_fill) peak_fill = model_count;
      end
    end else begin
      remove_count++;
      if (model_count == 0) begin
        st = spq_pkg::STAT_EMPTY;
        empty_removes++;
      end else begin
        for (i = 1; i < model_count; i++) begin
          model_payload[i-1] = model_payload[i];
          model_prio[i-1]    = model_prio[i];
        end
        model_count--;
      end
    end
    if (model_count > 0)
      r = mk_report(st, model_count[spq_pkg::COUNT_W-1:0], 1'b1, model_prio[0],
                    model_payload[0]);
    else
      r = mk_report(st, '0, 1'b0, '0, '0);
  endtask

  // Offer one word; on acceptance queue the expected head report.
  task automatic send_word(input logic m, input logic [spq_pkg::FIELD_DW-1:0] d,
                           input logic [spq_pkg::PRIO_W-1:0] p, input logic typed,
                           input head_report_t want);
    head_report_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {p, d};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_queue_model(m, d, p, predicted);
    expected_heads.push_back(typed ? want : predicted);
  endtask

  task automatic add_row(input logic m, input logic [spq_pkg::FIELD_DW-1:0] d,
                         input logic [spq_pkg::PRIO_W-1:0] p, input logic typed,
                         input head_report_t want);
    dir_row_t row;
    row.mode  = m;
    row.data  = d;
    row.prio  = p;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin : sink
    int held;
    held = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && held < HOLD_CYCLES) begin
        held++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    head_report_t got;
    head_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_heads.size() == 0) begin
        flag_error($sformatf("result word %h with nothing expected", got));
      end else begin
        want = expected_heads[0];
        expected_heads.delete(0);
        if (got.data !== want.data)
          flag_error($sformatf("word %0d head_data %h, want %h",
                               checked_count, got.data, want.data));
        if (got.prio !== want.prio)
          flag_error($sformatf("word %0d head_priority %0d, want %0d",
                               checked_count, got.prio, want.prio));
        if (got.valid !== want.valid)
          flag_error($sformatf("word %0d head_valid %b, want %b",
                               checked_count, got.valid, want.valid));
        if (got.count !== want.count)
          flag_error($sformatf("word %0d entry_count %0d, want %0d",
                               checked_count, got.count, want.count));
        if (got.status !== want.status)
          flag_error($sformatf("word %0d status %0d, want %0d",
                               checked_count, got.status, want.status));
        checked_count++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Stalled for %0d cycles with %0d results outstanding",
             QUIET_LIMIT, expected_heads.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    dir_row_t     row;
    head_report_t none;
    int           n;
    int           i;
    int           roll;
    logic         m;
    logic         filling;
    logic [spq_pkg::FIELD_DW-1:0] d;
    logic [spq_pkg::PRIO_W-1:0]   p;

    error_count   = 0;
    checked_count = 0;
    insert_count  = 0;
    remove_count  = 0;
    full_drops    = 0;
    empty_removes = 0;
    peak_fill     = 0;
    model_count   = 0;
    src_idle_pct  = 16;
    snk_idle_pct  = 82;
    hold_request  = 1'b0;
    none          = '0;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= spq_pkg::MODE_INSERT;

    // directed: empty, extremes, ties, drain to empty, fill to full
    add_row(spq_pkg::MODE_REMOVE, 32'h0, 16'h0, 1'b1,
            mk_report(spq_pkg::STAT_EMPTY, '0, 1'b0, '0, '0));
    add_row(spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'h7FFF, 1'b1,
            mk_report(spq_pkg::STAT_OK, spq_pkg::COUNT_W'(1), 1'b1, 16'h7FFF,
                      32'hFFFF_FFFF));
    add_row(spq_pkg::MODE_INSERT, 32'h0, 16'h8000, 1'b1,
            mk_report(spq_pkg::STAT_OK, spq_pkg::COUNT_W'(2), 1'b1, 16'h8000, 32'h0));
    // equal priority goes behind the earlier entry
    add_row(spq_pkg::MODE_INSERT, 32'h1234_5678, 16'h8000, 1'b0, none);
    add_row(spq_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, none);
    add_row(spq_pkg::MODE_REMOVE, 32'h0, 16'h0, 1'b0, none);
    add_row(spq_pkg::MODE_REMOVE, 32'h0, 16'h0, 1'b1,
            mk_report(spq_pkg::STAT_OK, '0, 1'b0, '0, '0));
    add_row(spq_pkg::MODE_REMOVE, 32'h0, 16'h0, 1'b1,
            mk_report(spq_pkg::STAT_EMPTY, '0, 1'b0, '0, '0));
    add_row(spq_pkg::MODE_INSERT, 32'hA5A5_A5A5, 16'h8000, 1'b1,
            mk_report(spq_pkg::STAT_OK, spq_pkg::COUNT_W'(1), 1'b1, 16'h8000,
                      32'hA5A5_A5A5));
    for (i = 0; i < QDEPTH - 1; i++)
      add_row(spq_pkg::MODE_INSERT, 32'h5A5A_0000 + i,
              spq_pkg::PRIO_W'((i % 5) * 7 - 14), 1'b0, none);
    add_row(spq_pkg::MODE_INSERT, 32'hDEAD_BEEF, 16'h8000, 1'b1,
            mk_report(spq_pkg::STAT_FULL, spq_pkg::COUNT_W'(QDEPTH), 1'b1, 16'h8000,
                      32'hA5A5_A5A5));
    add_row(spq_pkg::MODE_REMOVE, 32'h0, 16'h0, 1'b0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_word(row.mode, row.data, row.prio, row.typed, row.want);
    end

    // random: sweep the fill level up and down, lingering at full and empty
    filling = 1'b1;
    for (n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 3) begin
        src_idle_pct = 82;
        snk_idle_pct = 16;
      end
      if (n == 2 * RAND_WORDS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 1'b1;
      end
      if (filling && model_count >= QDEPTH && $urandom_range(0, 3) == 0)
        filling = 1'b0;
      else if (!filling && model_count == 0 && $urandom_range(0, 3) == 0)
        filling = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 10)
        m = 1'($urandom_range(0, 1));
      else
        m = ($urandom_range(0, 99) < (filling ? 80 : 20)) ? spq_pkg::MODE_INSERT
                                                          : spq_pkg::MODE_REMOVE;

      d    = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 40)
        p = spq_pkg::PRIO_W'($urandom_range(0, 7)) - spq_pkg::PRIO_W'(4);  // many ties
      else if (roll < 50)
        case ($urandom_range(0, 3))
          0: p = 16'h8000;
          1: p = 16'h7FFF;
          2: p = 16'h0000;
          default: p = 16'hFFFF;
        endcase
      else
        p = spq_pkg::PRIO_W'($urandom_range(0, 65535));

      send_word(m, d, p, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_heads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d result words: %0d inserts (%0d dropped on full), %0d removes",
             checked_count, insert_count, full_drops, remove_count);
    $display("  (%0d on empty), peak fill %0d of %0d, one %0d-cycle receiver hold",
             empty_removes, peak_fill, QDEPTH, HOLD_CYCLES);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
